// ===== rtl/wide_integer_alu_128_unit_macros.svh =====
// Assertion macros used by the wide integer ALU controller.
`ifndef WIDE_INTEGER_ALU_128_UNIT_MACROS_SVH
`define WIDE_INTEGER_ALU_128_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define WIA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define WIA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wia_pkg.sv =====
// Types and constants shared by the wide integer ALU modules.
package wia_pkg;

    localparam int WORD_W  = 64;
    localparam int LIMB_W  = 32;
    localparam int STEP_W  = 8;
    localparam int SHIFT_W = 7;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_AND = 4'd4,
        CMD_OR  = 4'd5,
        CMD_XOR = 4'd6,
        CMD_NOT = 4'd7,
        CMD_SHL = 4'd8,
        CMD_SHR = 4'd9,
        CMD_INC = 4'd10,
        CMD_CMP = 4'd11
    } cmd_t;

    localparam logic [1:0] ORD_EQ = 2'd0;
    localparam logic [1:0] ORD_LT = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic              load;
        logic              calc;
        logic              mul_step;
        logic              div_step;
        logic [STEP_W-1:0] step;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic b_zero;
    } dp_status_t;

endpackage

// ===== rtl/wia_datapath.sv =====
// Datapath: operand registers, combinational ALU, multiply accumulator and divider step.
module wia_datapath import wia_pkg::*; #(
    parameter int WORD_COUNT = 2
) (
    input  logic               aclk,
    input  ctrl_cmd_t          ctrl,
    input  logic [3:0]         in_cmd,
    input  logic [64*WORD_COUNT-1:0] in_a,
    input  logic [64*WORD_COUNT-1:0] in_b,
    input  logic [SHIFT_W-1:0] in_shift,
    output dp_status_t         status,
    output logic [64*WORD_COUNT-1:0] res,
    output logic [64*WORD_COUNT-1:0] rem,
    output logic [1:0]         order,
    output logic               div_zero,
    output logic               res_zero
);
    localparam int W     = WORD_W * WORD_COUNT;
    localparam int LIMBS = W / LIMB_W;
    localparam int LB    = $clog2(LIMBS);

    logic [W-1:0]        a_reg, b_reg, res_reg, rem_reg;
    logic [W-1:0]        res_next, rem_next, a_next;
    logic [3:0]          cmd_reg;
    logic [SHIFT_W-1:0]  sh_reg;
    logic [1:0]          order_reg, order_next;
    logic                dz_reg, dz_next;
    logic [2*LIMB_W-1:0] p_reg, p_next;
    logic [LB:0]         psh_reg, psh_next;
    logic [W-1:0]        calc_res;
    logic [1:0]          calc_ord;
    logic [LB-1:0]       li, lj;
    logic [W-1:0]        r_shift;
    logic [W:0]          diff;

    assign status.cmd    = cmd_t'(cmd_reg);
    assign status.b_zero = (b_reg == '0);

    always_comb begin
        calc_ord = ORD_EQ;
        if (a_reg > b_reg) begin
            calc_ord = ORD_GT;
        end else if (a_reg < b_reg) begin
            calc_ord = ORD_LT;
        end
        case (cmd_reg)
            CMD_ADD: calc_res = a_reg + b_reg;
            CMD_SUB: calc_res = a_reg - b_reg;
            CMD_DIV: calc_res = '1;
            CMD_AND: calc_res = a_reg & b_reg;
            CMD_OR:  calc_res = a_reg | b_reg;
            CMD_XOR: calc_res = a_reg ^ b_reg;
            CMD_NOT: calc_res = ~a_reg;
            CMD_SHL: calc_res = a_reg << sh_reg;
            CMD_SHR: calc_res = a_reg >> sh_reg;
            CMD_INC: calc_res = a_reg + W'(1);
            default: calc_res = '0;
        endcase
    end

    assign li      = ctrl.step[2*LB-1:LB];
    assign lj      = ctrl.step[LB-1:0];
    assign r_shift = {rem_reg[W-2:0], a_reg[W-1]};
    assign diff    = {rem_reg[W-1], r_shift} - {1'b0, b_reg};

    always_comb begin
        res_next   = res_reg;
        rem_next   = rem_reg;
        a_next     = a_reg;
        order_next = order_reg;
        dz_next    = dz_reg;
        p_next     = p_reg;
        psh_next   = psh_reg;
        if (ctrl.load) begin
            res_next   = '0;
            rem_next   = '0;
            order_next = ORD_EQ;
            dz_next    = 1'b0;
            a_next     = in_a;
        end else if (ctrl.calc) begin
            res_next = calc_res;
            if (cmd_reg == CMD_DIV) begin
                rem_next = a_reg;
                dz_next  = 1'b1;
            end
            if (cmd_reg == CMD_CMP) begin
                order_next = calc_ord;
            end
        end else if (ctrl.mul_step) begin
            p_next   = a_reg[li*LIMB_W +: LIMB_W] * b_reg[lj*LIMB_W +: LIMB_W];
            psh_next = {1'b0, li} + {1'b0, lj};
            if (ctrl.step != '0) begin
                res_next = res_reg + (W'(p_reg) << (LIMB_W * psh_reg));
            end
        end else if (ctrl.div_step) begin
            a_next = a_reg << 1;
            if (!diff[W]) begin
                rem_next = diff[W-1:0];
                res_next = {res_reg[W-2:0], 1'b1};
            end else begin
                rem_next = r_shift;
                res_next = {res_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            b_reg   <= in_b;
            cmd_reg <= in_cmd;
            sh_reg  <= in_shift;
        end
        a_reg     <= a_next;
        res_reg   <= res_next;
        rem_reg   <= rem_next;
        order_reg <= order_next;
        dz_reg    <= dz_next;
        p_reg     <= p_next;
        psh_reg   <= psh_next;
    end

    assign res      = res_reg;
    assign rem      = rem_reg;
    assign order    = order_reg;
    assign div_zero = dz_reg;
    assign res_zero = (res_reg == '0);

endmodule

// ===== rtl/wia_controller.sv =====
// Controller state machine that sequences the wide integer ALU datapath.
`include "wide_integer_alu_128_unit_macros.svh"
module wia_controller import wia_pkg::*; #(
    parameter int WORD_COUNT = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  ctrl
);
    localparam int MUL_LAST = 4 * WORD_COUNT * WORD_COUNT;
    localparam int DIV_LAST = WORD_W * WORD_COUNT - 1;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (status.cmd == CMD_MUL) begin
                    state_next = S_MUL;
                end else if (status.cmd == CMD_DIV && !status.b_zero) begin
                    state_next = S_DIV;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_MUL: begin
                if (step_reg == STEP_W'(MUL_LAST)) begin
                    state_next = S_OUT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DIV: begin
                if (step_reg == STEP_W'(DIV_LAST)) begin
                    state_next = S_OUT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        ctrl.load     = 1'b0;
        ctrl.calc     = 1'b0;
        ctrl.mul_step = 1'b0;
        ctrl.div_step = 1'b0;
        ctrl.step     = step_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
            end
            S_DECODE: begin
                ctrl.calc = !(status.cmd == CMD_MUL ||
                              (status.cmd == CMD_DIV && !status.b_zero));
            end
            S_MUL:   ctrl.mul_step = 1'b1;
            S_DIV:   ctrl.div_step = 1'b1;
            S_OUT:   m_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `WIA_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_tready, state_reg == S_DECODE, "accepted transaction did not start decode")
    `WIA_ASSERT_NEXT(a_div_ends_in_out, aclk, aresetn, state_reg == S_DIV && step_reg == STEP_W'(DIV_LAST), m_tvalid, "division did not finish with a result")
    `WIA_ASSERT_IMPL(a_mul_step_bound, aclk, aresetn, state_reg == S_MUL, step_reg <= STEP_W'(MUL_LAST), "multiply step counter overran")
    `WIA_ASSERT_NEXT(a_out_fire_idle, aclk, aresetn, m_tvalid && m_tready, s_tready, "controller did not return to idle after result transaction")

endmodule

// ===== rtl/wide_integer_alu_128_unit.sv =====
// Top level of the wide integer ALU: stream ports around controller and datapath.
// Usage: one command transaction enters on the s_ channel (s_tuser holds the command,
// s_tdata the operands and shift count); exactly one result transaction leaves on the
// m_ channel. The unit works on one transaction at a time: s_tready is high only while
// it is idle, and the next command is taken the cycle after the result is taken.
// Add, sub, logic, shift, inc, cmp and division by zero are computed in the decode state;
// multiply steps one 32x32 multiplier over the limb pairs, and division uses the
// restoring divider that yields one quotient bit per cycle. When the receiver stalls,
// the result stays in its registers with m_tvalid high until m_tready is seen; no new
// command is taken meanwhile. Reset (aresetn low, synchronous) returns the controller
// to idle and drops any transaction in progress. WORD_COUNT 1 gives a 64-bit ALU:
// high input words are ignored and high result words are zero.
module wide_integer_alu_128_unit import wia_pkg::*; #(
    parameter int WORD_COUNT = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_low, a_high, b_low, b_high, shift_amount, zero fill
    input  logic [263:0] s_tdata,
    // command
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_low, result_high, remainder_low, remainder_high, order, divide_by_zero,
    // result_zero, zero fill
    output logic [263:0] m_tdata
);
    localparam int W = WORD_W * WORD_COUNT;

    ctrl_cmd_t    ctrl;
    dp_status_t   status;
    logic [W-1:0] res, rem;
    logic [1:0]   order;
    logic         div_zero, res_zero;
    logic [127:0] res_wide, rem_wide;

    wia_controller #(.WORD_COUNT(WORD_COUNT)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    wia_datapath #(.WORD_COUNT(WORD_COUNT)) u_dp (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .in_cmd   (s_tuser),
        .in_a     (W'(s_tdata[127:0])),
        .in_b     (W'(s_tdata[255:128])),
        .in_shift (s_tdata[262:256]),
        .status   (status),
        .res      (res),
        .rem      (rem),
        .order    (order),
        .div_zero (div_zero),
        .res_zero (res_zero)
    );

    assign res_wide = 128'(res);
    assign rem_wide = 128'(rem);
    assign m_tdata  = {4'd0, res_zero, div_zero, order, rem_wide, res_wide};

endmodule
